// File: sv/mru_history_list_macros.svh
// assertion macros for the mru history list checker
`ifndef MRU_HISTORY_LIST_MACROS_SVH
`define MRU_HISTORY_LIST_MACROS_SVH

// property must hold at every edge out of reset
`define MHL_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: property violated");

// expression must never be true out of reset
`define MHL_NEVER(name, clk, rst_n, expr) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("%m: forbidden condition seen");

`endif

// File: sv/mhl_pkg.sv
`default_nettype none

package mhl_pkg;

	// list capacity and id space
	localparam int MAX_HISTORY = 16;
	localparam int MAX_ENTRIES = 256;

	// derived widths
	localparam int ID_W    = $clog2(MAX_ENTRIES);
	localparam int ADDR_W  = $clog2(MAX_HISTORY);
	localparam int CNT_W   = $clog2(MAX_HISTORY + 1);
	localparam int POS_W   = 5;
	localparam int ECNT_W  = 9;
	localparam int LIMIT_W = 5;
	localparam int CFG_W   = 9;

	// input operations
	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// configuration register indexes
	localparam logic REG_ENTRY_COUNT   = 1'b0;
	localparam logic REG_HISTORY_LIMIT = 1'b1;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(MAX_HISTORY);

	// sequencer states
	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_LOOK = 7'b0000010,
		ST_SCAN = 7'b0000100,
		ST_SCMP = 7'b0001000,
		ST_SHRD = 7'b0010000,
		ST_SHWR = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

endpackage

`default_nettype wire

// File: sv/mhl_if.sv
`default_nettype none

// request channel
interface hist_req_if;
	logic                       valid;
	logic                       ready;
	logic                       opcode;
	logic [mhl_pkg::ID_W-1:0]  item_id;
	logic [mhl_pkg::POS_W-1:0] position;

	modport source (output valid, output opcode, output item_id, output position, input ready);
	modport sink (input valid, input opcode, input item_id, input position, output ready);
endinterface

// response channel
interface hist_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [mhl_pkg::ID_W-1:0]  result_id;
	logic                       result_valid;
	logic [mhl_pkg::CNT_W-1:0] history_length;

	modport source (output valid, output result_id, output result_valid,
		output history_length, input ready);
	modport sink (input valid, input result_id, input result_valid,
		input history_length, output ready);
endinterface

// configuration write channel
interface hist_cfg_if;
	logic                       valid;
	logic                       ready;
	logic                       index;
	logic [mhl_pkg::CFG_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: sv/mhl_ram.sv
`default_nettype none

module mhl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: sv/mru_history_list.sv
// channel | dir | payload
// req     | in  | opcode, item_id, position
// rsp     | out | result_id, result_valid, history_length
// cfg     | in  | index (0 entry_count, 1 history_limit), data; always ready
//
// a lookup reads the entry at its position; an append whose id is at or past entry_count is ignored;
// any other append scans the listed entries with the single compare unit, then moves
// entries back by alternate reads and writes of the list ram and puts the id at the
// front (a new id is dropped when the history limit is zero)
// the next request is taken once the sequencer is back in idle, even while a
// result still waits in the output register; it stalls only when a second
// result is ready and the first has not gone
// reset clears the list length and control; the list ram needs no clearing
`default_nettype none

module mru_history_list (
	input wire logic  clk,
	input wire logic  arst_n,
	hist_req_if.sink   req,
	hist_rsp_if.source rsp,
	hist_cfg_if.sink   cfg
);

	mhl_pkg::state_t state_q;

	logic [mhl_pkg::ECNT_W-1:0]  entry_count_q;
	logic [mhl_pkg::LIMIT_W-1:0] history_limit_q;
	logic [mhl_pkg::CNT_W-1:0]   count_q;
	logic [mhl_pkg::CNT_W-1:0]   idx_q;
	logic [mhl_pkg::ADDR_W-1:0]  k_q;
	logic [mhl_pkg::ID_W-1:0]    id_q;
	logic [mhl_pkg::ID_W-1:0]    res_id_q;
	logic                        res_valid_q;
	logic                        out_valid_q;
	logic [mhl_pkg::ID_W-1:0]    out_id_q;
	logic                        out_ok_q;
	logic [mhl_pkg::CNT_W-1:0]   out_len_q;

	logic                        ram_we;
	logic [mhl_pkg::ADDR_W-1:0]  ram_waddr;
	logic [mhl_pkg::ID_W-1:0]    ram_wdata;
	logic                        ram_re;
	logic [mhl_pkg::ADDR_W-1:0]  ram_raddr;
	logic [mhl_pkg::ID_W-1:0]    ram_rdata;

	logic [mhl_pkg::CNT_W-1:0]   limit;
	logic [mhl_pkg::CNT_W-1:0]   cut_count;
	logic                        req_xfer;
	logic                        out_free;

	assign req_xfer = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;

	// effective limit and the length left after a cut
	always_comb begin
		if (history_limit_q > mhl_pkg::LIMIT_W'(mhl_pkg::MAX_HISTORY)) begin
			limit = mhl_pkg::CNT_W'(mhl_pkg::MAX_HISTORY);
		end else begin
			limit = mhl_pkg::CNT_W'(history_limit_q);
		end
		if (count_q >= limit) begin
			cut_count = limit - mhl_pkg::CNT_W'(1);
		end else begin
			cut_count = count_q;
		end
	end

	// ram port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = k_q;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = k_q - mhl_pkg::ADDR_W'(1);
		unique case (state_q)
			mhl_pkg::ST_IDLE: begin
				ram_re    = req_xfer;
				ram_raddr = req.position[mhl_pkg::ADDR_W-1:0];
			end
			mhl_pkg::ST_SCAN: begin
				ram_re    = 1'b1;
				ram_raddr = idx_q[mhl_pkg::ADDR_W-1:0];
			end
			mhl_pkg::ST_SHRD: begin
				if (k_q == '0) begin
					ram_we    = 1'b1;
					ram_wdata = id_q;
				end else begin
					ram_re = 1'b1;
				end
			end
			mhl_pkg::ST_SHWR: begin
				ram_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	mhl_ram #(
		.WIDTH(mhl_pkg::ID_W),
		.DEPTH(mhl_pkg::MAX_HISTORY)
	) u_list (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.re     (ram_re),
		.raddr  (ram_raddr),
		.rdata_q(ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q   <= '0;
			history_limit_q <= mhl_pkg::LIMIT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				mhl_pkg::REG_ENTRY_COUNT:   entry_count_q   <= cfg.data;
				mhl_pkg::REG_HISTORY_LIMIT: history_limit_q <= cfg.data[mhl_pkg::LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mhl_pkg::ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				mhl_pkg::ST_IDLE: begin
					if (req_xfer) begin
						idx_q <= '0;
						if (req.opcode == mhl_pkg::OP_LOOKUP) begin
							if (req.position < mhl_pkg::POS_W'(count_q)) begin
								state_q <= mhl_pkg::ST_LOOK;
							end else begin
								state_q <= mhl_pkg::ST_DONE;
							end
						end else if ({1'b0, req.item_id} >= entry_count_q) begin
							state_q <= mhl_pkg::ST_DONE;
						end else begin
							state_q <= mhl_pkg::ST_SCAN;
						end
					end
				end
				mhl_pkg::ST_LOOK: begin
					state_q <= mhl_pkg::ST_DONE;
				end
				mhl_pkg::ST_SCAN: begin
					if (idx_q < count_q) begin
						state_q <= mhl_pkg::ST_SCMP;
					end else if (limit == '0) begin
						state_q <= mhl_pkg::ST_DONE;
					end else begin
						count_q <= cut_count + mhl_pkg::CNT_W'(1);
						k_q     <= cut_count[mhl_pkg::ADDR_W-1:0];
						state_q <= mhl_pkg::ST_SHRD;
					end
				end
				mhl_pkg::ST_SCMP: begin
					if (ram_rdata == id_q) begin
						k_q     <= idx_q[mhl_pkg::ADDR_W-1:0];
						state_q <= mhl_pkg::ST_SHRD;
					end else begin
						idx_q   <= idx_q + mhl_pkg::CNT_W'(1);
						state_q <= mhl_pkg::ST_SCAN;
					end
				end
				mhl_pkg::ST_SHRD: begin
					if (k_q == '0) begin
						state_q <= mhl_pkg::ST_DONE;
					end else begin
						state_q <= mhl_pkg::ST_SHWR;
					end
				end
				mhl_pkg::ST_SHWR: begin
					k_q     <= k_q - mhl_pkg::ADDR_W'(1);
					state_q <= mhl_pkg::ST_SHRD;
				end
				mhl_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= mhl_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= mhl_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// item payload and pending result
	always_ff @(posedge clk) begin
		if (state_q == mhl_pkg::ST_IDLE && req_xfer) begin
			id_q        <= req.item_id;
			res_id_q    <= '0;
			res_valid_q <= 1'b0;
		end else if (state_q == mhl_pkg::ST_LOOK) begin
			res_id_q    <= ram_rdata;
			res_valid_q <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == mhl_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mhl_pkg::ST_DONE && out_free) begin
			out_id_q  <= res_id_q;
			out_ok_q  <= res_valid_q;
			out_len_q <= count_q;
		end
	end

	assign req.ready          = (state_q == mhl_pkg::ST_IDLE);
	assign cfg.ready          = 1'b1;
	assign rsp.valid          = out_valid_q;
	assign rsp.result_id      = out_id_q;
	assign rsp.result_valid   = out_ok_q;
	assign rsp.history_length = out_len_q;

endmodule

`default_nettype wire

// File: sv/mhl_checker.sv
`default_nettype none
`include "mru_history_list_macros.svh"

module mhl_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       req_valid,
	input wire logic                       req_ready,
	input wire logic                       rsp_valid,
	input wire logic                       rsp_ready,
	input wire logic [mhl_pkg::ID_W-1:0]  rsp_result_id,
	input wire logic                       rsp_result_valid,
	input wire logic [mhl_pkg::CNT_W-1:0] rsp_history_length
);

	// a stalled result keeps its id and its history length
	`MHL_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_id) && $stable(rsp_history_length))

	// a result that is not valid carries a zero id
	`MHL_NEVER(a_invalid_zero, clk, arst_n, rsp_valid && !rsp_result_valid && rsp_result_id != '0)

	// the list never grows past its capacity
	`MHL_NEVER(a_len_cap, clk, arst_n, rsp_valid && rsp_history_length > mhl_pkg::CNT_W'(mhl_pkg::MAX_HISTORY))

	// a request transfer takes the block busy for at least the next cycle
	`MHL_ASSERT(a_busy_after_req, clk, arst_n, req_valid && req_ready |=> !req_ready)

endmodule

bind mru_history_list mhl_checker u_mhl_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_result_id     (rsp.result_id),
	.rsp_result_valid  (rsp.result_valid),
	.rsp_history_length(rsp.history_length)
);

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import mhl_pkg::*;

	localparam int DRAIN_CYCLES   = 80;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_COUNT    = 12;
	localparam int PHASE_ITEMS    = 65;

	// one response as the block reports it
	typedef struct packed {
		logic [ID_W-1:0]  rid;
		logic             rvalid;
		logic [CNT_W-1:0] len;
	} hist_result_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	// one line of the directed stimulus
	typedef struct packed {
		row_kind_t        kind;
		logic             op;
		logic [ID_W-1:0]  id;
		logic [POS_W-1:0] pos;
		logic             reg_idx;
		logic [CFG_W-1:0] data;
		logic             typed;
		hist_result_t     res;
	} stim_row_t;

	logic clk;
	logic arst_n;

	hist_req_if req_ch();
	hist_rsp_if rsp_ch();
	hist_cfg_if cfg_ch();

	mru_history_list DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// predicted list state and register copies
	logic [ID_W-1:0]    mru_ids [MAX_HISTORY];
	logic [CNT_W-1:0]   mru_len;
	logic [ECNT_W-1:0]  cfg_entry_count;
	logic [LIMIT_W-1:0] cfg_history_limit;

	hist_result_t pending_results[$];

	int errors;
	int appends_sent;
	int lookups_sent;
	int results_seen;
	int reg_writes;
	int longest_list;
	int send_idle_pct;
	int recv_idle_pct;
	int stall_mixes;
	bit holdoff_req;

	// clock
	initial begin
		clk = 1'b0;
	end
	always #2 clk = ~clk;

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	function automatic int eff_entries();
		return (cfg_entry_count > MAX_ENTRIES) ? MAX_ENTRIES : int'(cfg_entry_count);
	endfunction

	function automatic int eff_limit();
		return (cfg_history_limit > MAX_HISTORY) ? MAX_HISTORY : int'(cfg_history_limit);
	endfunction

	// move-to-front list update and lookup for one request
	function automatic hist_result_t mru_predict(input logic op, input logic [ID_W-1:0] id,
		input logic [POS_W-1:0] pos);
		hist_result_t r;
		int hit;
		int lim;
		int n;
		r = '0;
		hit = -1;
		lim = eff_limit();
		if (op == OP_APPEND) begin
			if (int'(id) < eff_entries()) begin
				for (int i = 0; i < int'(mru_len) && i < MAX_HISTORY; i++)
					if (hit < 0 && mru_ids[i] == id) hit = i;
				if (hit >= 0) begin
					// already listed: bring to the front, length unchanged
					for (int j = hit; j > 0; j--) mru_ids[j] = mru_ids[j-1];
					mru_ids[0] = id;
				end else if (lim != 0) begin
					n = int'(mru_len);
					if (n >= lim) n = lim - 1;
					for (int j = n; j > 0; j--)
						if (j < MAX_HISTORY) mru_ids[j] = mru_ids[j-1];
					mru_ids[0] = id;
					mru_len = CNT_W'(n + 1);
				end
			end
		end else if (int'(pos) < int'(mru_len) && int'(pos) < MAX_HISTORY) begin
			r.rid = mru_ids[pos[ADDR_W-1:0]];
			r.rvalid = 1'b1;
		end
		r.len = mru_len;
		if (int'(mru_len) > longest_list) longest_list = int'(mru_len);
		return r;
	endfunction

	// offer one request, with random idle cycles ahead of it
	task automatic send_item(input logic op, input logic [ID_W-1:0] id,
		input logic [POS_W-1:0] pos, input bit use_typed, input hist_result_t typed_res);
		hist_result_t r;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.opcode = op;
		req_ch.item_id = id;
		req_ch.position = pos;
		do @(posedge clk); while (!req_ch.ready);
		r = mru_predict(op, id, pos);
		if (use_typed) r = typed_res;
		pending_results = {pending_results, r};
		if (op == OP_APPEND) appends_sent++;
		else lookups_sent++;
	endtask

	// stop offering, let every result come back, then let the block settle
	task automatic settle_idle();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic idx, input int value);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = CFG_W'(value);
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == REG_ENTRY_COUNT) cfg_entry_count = ECNT_W'(value);
		else cfg_history_limit = LIMIT_W'(value);
		reg_writes++;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	function automatic stim_row_t item_row(input logic op, input int id, input int pos);
		stim_row_t row;
		row = '0;
		row.kind = ROW_ITEM;
		row.op = op;
		row.id = ID_W'(id);
		row.pos = POS_W'(pos);
		return row;
	endfunction

	function automatic stim_row_t typed_row(input logic op, input int id, input int pos,
		input int rid, input int rvalid, input int len);
		stim_row_t row;
		row = item_row(op, id, pos);
		row.typed = 1'b1;
		row.res.rid = ID_W'(rid);
		row.res.rvalid = rvalid[0];
		row.res.len = CNT_W'(len);
		return row;
	endfunction

	function automatic stim_row_t cfg_row(input logic idx, input int value);
		stim_row_t row;
		row = '0;
		row.kind = ROW_CFG;
		row.reg_idx = idx;
		row.data = CFG_W'(value);
		return row;
	endfunction

	// random request fields, mostly ids from a small pool so they repeat
	function automatic logic [ID_W-1:0] pick_id();
		int span;
		int r;
		int lo;
		int hi;
		span = eff_entries();
		r = $urandom_range(99);
		if (r < 70 && span > 0)
			return ID_W'($urandom_range((span > 24 ? 24 : span) - 1));
		if (r < 90) begin
			lo = (span > 2) ? span - 2 : 0;
			hi = (span + 1 > 255) ? 255 : span + 1;
			return ID_W'($urandom_range(hi, lo));
		end
		return ID_W'($urandom_range(255));
	endfunction

	function automatic logic [POS_W-1:0] pick_pos();
		int hi;
		hi = int'(mru_len) + 1;
		if (hi > 31) hi = 31;
		if ($urandom_range(99) < 80) return POS_W'($urandom_range(hi));
		return POS_W'($urandom_range(31));
	endfunction

	// response side: ready pattern and the long hold-off
	initial begin : rsp_driver
		int holdoff_left;
		holdoff_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_req) begin
				holdoff_left = HOLDOFF_CYCLES;
				holdoff_req = 1'b0;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				rsp_ch.ready = 1'b0;
			end else begin
				rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// compare every response transfer with the oldest prediction
	always @(posedge clk) begin : rsp_check
		hist_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", 1, 0);
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.result_id !== want.rid)
					report_mismatch("result_id", rsp_ch.result_id, want.rid);
				if (rsp_ch.result_valid !== want.rvalid)
					report_mismatch("result_valid", rsp_ch.result_valid, want.rvalid);
				if (rsp_ch.history_length !== want.len)
					report_mismatch("history_length", rsp_ch.history_length, want.len);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin : watchdog
		int quiet;
		if (!arst_n) begin
			quiet = 0;
		end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	// stimulus
	initial begin : stimulus
		stim_row_t directed[$];
		int phase_entries[PHASE_COUNT];
		int phase_limit[PHASE_COUNT];
		int ec;
		int lim;
		hist_result_t none;

		none = '0;
		errors = 0;
		appends_sent = 0;
		lookups_sent = 0;
		results_seen = 0;
		reg_writes = 0;
		longest_list = 0;
		stall_mixes = 0;
		holdoff_req = 1'b0;
		send_idle_pct = 25;
		recv_idle_pct = 75;

		req_ch.valid = 1'b0;
		req_ch.opcode = OP_APPEND;
		req_ch.item_id = '0;
		req_ch.position = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_ENTRY_COUNT;
		cfg_ch.data = '0;

		// predictor starts from the reset state
		mru_len = '0;
		cfg_entry_count = '0;
		cfg_history_limit = LIMIT_RESET;
		for (int i = 0; i < MAX_HISTORY; i++) mru_ids[i] = '0;

		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset values, extremes, move to front, limit cases
		directed = '{
			typed_row(OP_LOOKUP, 0, 0, 0, 0, 0),
			typed_row(OP_LOOKUP, 0, 31, 0, 0, 0),
			typed_row(OP_APPEND, 0, 0, 0, 0, 0),
			typed_row(OP_APPEND, 255, 0, 0, 0, 0),
			cfg_row(REG_ENTRY_COUNT, 511),
			typed_row(OP_APPEND, 255, 0, 0, 0, 1),
			typed_row(OP_LOOKUP, 0, 0, 255, 1, 1),
			typed_row(OP_APPEND, 0, 0, 0, 0, 2),
			item_row(OP_APPEND, 8'hAA, 0),
			item_row(OP_APPEND, 8'h55, 31),
			item_row(OP_APPEND, 255, 0),
			item_row(OP_LOOKUP, 0, 3),
			typed_row(OP_LOOKUP, 255, 4, 0, 0, 4),
			cfg_row(REG_HISTORY_LIMIT, 2),
			item_row(OP_APPEND, 8'hAA, 0),
			item_row(OP_APPEND, 7, 0),
			item_row(OP_LOOKUP, 0, 1),
			cfg_row(REG_HISTORY_LIMIT, 0),
			item_row(OP_APPEND, 9, 0),
			item_row(OP_APPEND, 8'hAA, 0),
			cfg_row(REG_HISTORY_LIMIT, 31),
			cfg_row(REG_ENTRY_COUNT, 3),
			item_row(OP_APPEND, 3, 0),
			item_row(OP_APPEND, 2, 0),
			item_row(OP_LOOKUP, 0, 2)
		};
		foreach (directed[k]) begin
			if (directed[k].kind == ROW_CFG) begin
				settle_idle();
				cfg_write(directed[k].reg_idx, int'(directed[k].data));
			end else begin
				send_item(directed[k].op, directed[k].id, directed[k].pos,
					directed[k].typed, directed[k].typed ? directed[k].res : none);
			end
		end

		// random phases, each under its own register setting
		phase_entries = '{256, 20, 12, 300, 6, 511, 16, 1, 257, 0, 40, -1};
		phase_limit   = '{16, 31, 4, 1, 0, 16, 17, 16, 3, 16, 8, -1};
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			settle_idle();
			case (ph / 4)
				0: begin
					send_idle_pct = 25;
					recv_idle_pct = 75;
				end
				1: begin
					send_idle_pct = 75;
					recv_idle_pct = 25;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (ph % 4 == 0) stall_mixes++;
			ec = (phase_entries[ph] < 0) ? $urandom_range(511) : phase_entries[ph];
			lim = (phase_limit[ph] < 0) ? $urandom_range(31) : phase_limit[ph];
			cfg_write(REG_ENTRY_COUNT, ec);
			cfg_write(REG_HISTORY_LIMIT, lim);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(99) < 40)
					send_item(OP_LOOKUP, ID_W'($urandom_range(255)), pick_pos(), 1'b0, none);
				else
					send_item(OP_APPEND, pick_id(), POS_W'($urandom_range(31)), 1'b0, none);
				// long receiver hold-off while requests keep coming
				if ((ph == 1 || ph == 9) && n == 10) holdoff_req = 1'b1;
				// pause the requests until the block has answered everything
				if (ph == 5 && n == 30) settle_idle();
			end
		end

		settle_idle();
		$display("covered %0d requests (%0d appends, %0d lookups), %0d results checked",
			appends_sent + lookups_sent, appends_sent, lookups_sent, results_seen);
		$display("%0d register writes, %0d stall mixes, list length reached %0d",
			reg_writes, stall_mixes, longest_list);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
